// File: rtl/core/ppsched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsched_pkg : shared types and constants of the priority scheduler
// Table geometry, payload structs, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ppsched_pkg;

  // Table geometry
  localparam int MaxTasks   = 16;
  localparam int IdxW       = $clog2(MaxTasks);
  localparam int CntW       = $clog2(MaxTasks + 1);
  localparam int TaskCountW = 5;
  localparam int LimW       = (CntW > TaskCountW) ? CntW : TaskCountW;

  // Field widths
  localparam int SlotW  = 4;
  localparam int LabelW = 8;
  localparam int PrioW  = 8;
  localparam int ArrW   = 16;
  localparam int BurstW = 16;
  localparam int TimeW  = 20;

  localparam logic [TimeW-1:0]      TimeMax        = {TimeW{1'b1}};
  localparam logic [TaskCountW-1:0] TaskCountReset = TaskCountW'(16);

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SlotW-1:0]  slot;
    logic [LabelW-1:0] label;
    logic [PrioW-1:0]  priority_req;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } in_t;

  typedef struct packed {
    logic              ran_valid;
    logic [SlotW-1:0]  ran_slot;
    logic [LabelW-1:0] ran_label;
    logic [TimeW-1:0]  time_now;
    logic              finished;
    logic [TimeW-1:0]  turnaround;
    logic [TimeW-1:0]  waiting;
    logic              all_done;
  } out_t;

  // One table row
  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [PrioW-1:0]  prio;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [BurstW-1:0] remain;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_step;
    logic update;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/ppsched_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsched_ctrl : scheduler sequencer
// Takes one item at a time, steps the datapath through load or slot scan
// and update, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ppsched_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppsched_pkg::status_t status_i,
  output ppsched_pkg::cmd_t    cmd_o
);
  import ppsched_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_tick ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD:   state_d = ST_RESP;
      ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOAD:   cmd_o.load_wr = 1'b1;
      ST_SCAN:   cmd_o.scan_step = !status_i.scan_end;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_RESP:   cmd_o.resp = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Only one datapath operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.load_wr, cmd_o.scan_step, cmd_o.update, cmd_o.resp}))
    else $error("ppsched_ctrl: overlapping datapath commands");

  // One item in flight: no transfer straight after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ppsched_ctrl: second item taken while busy");

  // Result goes out only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp |-> status_i.out_free)
    else $error("ppsched_ctrl: result would overwrite pending output");
`endif

endmodule

// File: rtl/core/ppsched_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsched_dp : scheduler datapath
// Task table memory, finished flags, time counter, slot scan with the
// best-candidate registers, result build and output register.
// ----------------------------------------------------------------------------
module ppsched_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppsched_pkg::cmd_t                    cmd_i,
  output ppsched_pkg::status_t                 status_o,
  input  ppsched_pkg::in_t                     in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [ppsched_pkg::TaskCountW-1:0]   cfg_wdata_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output ppsched_pkg::out_t                    out_data_o
);
  import ppsched_pkg::*;

  // Configuration and captured item
  logic [TaskCountW-1:0] task_count_q;
  in_t                   in_q;

  // Table and flags
  entry_t                mem_q [MaxTasks];
  logic [MaxTasks-1:0]   mask_q;
  logic [TimeW-1:0]      clock_q;

  // Scan pipeline
  logic [LimW-1:0]       scan_cnt_q;
  logic                  cmp_en_q;
  logic [IdxW-1:0]       rd_idx_q;
  entry_t                rd_q;
  logic                  rd_done_q;

  // Best candidate
  logic                  best_found_q;
  logic [IdxW-1:0]       best_idx_q;
  entry_t                best_e_q;

  // Result holding
  logic                  res_ran_q;
  logic                  res_fin_q;
  logic [TimeW-1:0]      tat_q;

  logic                  out_valid_q;
  out_t                  out_q;

  logic [LimW-1:0]       lim;
  logic [IdxW-1:0]       scan_idx;
  logic                  slot_ok;
  logic [IdxW-1:0]       slot_idx;
  logic                  eligible;
  logic                  better;
  logic [TimeW-1:0]      clock_inc;
  logic                  fin_now;
  logic [BurstW-1:0]     remain_new;
  logic [TimeW-1:0]      tat_new;
  logic [TimeW-1:0]      burst_ext;
  logic [TimeW-1:0]      wait_val;
  logic                  all_done;
  entry_t                load_e;
  entry_t                upd_e;

  // Counted slots, clipped to the table size
  assign lim = (LimW'(task_count_q) > LimW'(MaxTasks)) ? LimW'(MaxTasks)
                                                       : LimW'(task_count_q);
  assign scan_idx = scan_cnt_q[IdxW-1:0];

  assign slot_ok  = LimW'(in_q.slot) < LimW'(MaxTasks);
  assign slot_idx = IdxW'(in_q.slot);

  // Status to the sequencer
  assign status_o.in_tick  = (in_data_i.action == ACT_TICK);
  assign status_o.scan_end = (scan_cnt_q == lim);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TaskCountReset;
    end else if (cfg_we_i) begin
      task_count_q <= cfg_wdata_i;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  // Row contents for a load and for the update of the running task
  always_comb begin
    load_e.label   = in_q.label;
    load_e.prio    = in_q.priority_req;
    load_e.arrival = in_q.arrival;
    load_e.burst   = in_q.burst;
    load_e.remain  = in_q.burst;
    upd_e          = best_e_q;
    upd_e.remain   = remain_new;
  end

  // Task table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && slot_ok) begin
      mem_q[slot_idx] <= load_e;
    end else if (cmd_i.update && best_found_q) begin
      mem_q[best_idx_q] <= upd_e;
    end
    if (cmd_i.scan_step) begin
      rd_q <= mem_q[scan_idx];
    end
  end

  // Scan address, read tag and finished flag alongside the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      cmp_en_q   <= 1'b0;
      rd_idx_q   <= '0;
      rd_done_q  <= 1'b1;
    end else begin
      cmp_en_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + LimW'(1);
        rd_idx_q   <= scan_idx;
        rd_done_q  <= mask_q[scan_idx];
      end
    end
  end

  // Candidate compare: priority, then arrival; lower slot wins by order
  assign eligible = !rd_done_q && (TimeW'(rd_q.arrival) <= clock_q);
  assign better   = !best_found_q || (rd_q.prio < best_e_q.prio) ||
                    ((rd_q.prio == best_e_q.prio) && (rd_q.arrival < best_e_q.arrival));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      best_found_q <= 1'b0;
    end else if (cmp_en_q && eligible && better) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q && eligible && better) begin
      best_idx_q <= rd_idx_q;
      best_e_q   <= rd_q;
    end
  end

  // Tick arithmetic
  assign clock_inc  = (clock_q != TimeMax) ? clock_q + TimeW'(1) : clock_q;
  assign fin_now    = (best_e_q.remain <= BurstW'(1));
  assign remain_new = fin_now ? '0 : best_e_q.remain - BurstW'(1);
  assign tat_new    = clock_inc - TimeW'(best_e_q.arrival);

  // Time counter and finished flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      mask_q  <= '1;
    end else begin
      if (cmd_i.update) begin
        clock_q <= clock_inc;
        if (best_found_q && fin_now) begin
          mask_q[best_idx_q] <= 1'b1;
        end
      end
      if (cmd_i.load_wr && slot_ok) begin
        mask_q[slot_idx] <= 1'b0;
      end
    end
  end

  // Result fields held until the output transfer is built
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      res_ran_q <= 1'b0;
      res_fin_q <= 1'b0;
      tat_q     <= '0;
    end else if (cmd_i.update) begin
      res_ran_q <= best_found_q;
      res_fin_q <= best_found_q && fin_now;
      tat_q     <= (best_found_q && fin_now) ? tat_new : '0;
    end
  end

  // Waiting time, floored at zero when saturation shortens turnaround
  assign burst_ext = TimeW'(best_e_q.burst);
  assign wait_val  = (res_fin_q && (tat_q > burst_ext)) ? tat_q - burst_ext : '0;

  // Every counted slot finished
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < MaxTasks; i++) begin
      if (!mask_q[i] && (LimW'(i) < lim)) begin
        all_done = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_q.ran_valid  <= res_ran_q;
      out_q.ran_slot   <= res_ran_q ? SlotW'(best_idx_q) : '0;
      out_q.ran_label  <= res_ran_q ? best_e_q.label : '0;
      out_q.time_now   <= clock_q;
      out_q.finished   <= res_fin_q;
      out_q.turnaround <= tat_q;
      out_q.waiting    <= wait_val;
      out_q.all_done   <= all_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Time never runs backwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q >= $past(clock_q))
    else $error("ppsched_dp: time counter decreased");

  // A completing task is flagged finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && best_found_q && fin_now |=> mask_q[best_idx_q])
    else $error("ppsched_dp: completed task not marked finished");

  // Scan stays within the counted slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (scan_cnt_q < lim))
    else $error("ppsched_dp: scan beyond counted slots");
`endif

endmodule

// File: rtl/core/preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core : preemptive priority task scheduler
// Load items fill a sixteen-slot task table; tick items run the most urgent
// eligible task for one unit and report its completion statistics.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item gives one result. A load passes
// through the load and result states. A tick scans min(task_count, 16) slots,
// one per cycle, as the task table has a single registered read port, then
// runs an update step and a result step that waits for a free output register.
// The next item is taken once the result is written there, even while it
// still waits for out_ready_i. No clearing pass follows reset; an unloaded slot
// stays finished and is never picked. The user writes task_count through
// cfg_we_i / cfg_wdata_i only while idle; the block itself does not enforce it.
module preemptive_priority_scheduler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ppsched_pkg::in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ppsched_pkg::out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [ppsched_pkg::TaskCountW-1:0] cfg_wdata_i
);
  import ppsched_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  ppsched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Table, scan and result path
  ppsched_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
